@@ rtl/rgain_pkg.sv @@
// Shared types, widths and register codes of the radial spectrum gain block.
`default_nettype none
package rgain_pkg;

	localparam int MAX_COEFFS     = 4;
	localparam int MAX_HALF_DIM   = 2048;
	localparam int NUM_COEFF_REGS = 4;
	localparam int N_LIM = (MAX_COEFFS < NUM_COEFF_REGS) ? MAX_COEFFS : NUM_COEFF_REGS;

	localparam int DIM_W   = 12;
	localparam int X_W     = 11;
	localparam int SQ_W    = 22;
	localparam int HSQ_W   = 23;
	localparam int NUM_W   = 46;
	localparam int Q_W     = 32;
	localparam int ROOT_W  = 16;
	localparam int COEF_W  = 16;
	localparam int E_W     = 20;
	localparam int CNT_W   = 3;
	localparam int IDX_W   = 3;
	localparam int DATA_W  = 16;
	localparam int BIN_W   = 32;

	// register indexes
	localparam logic [IDX_W-1:0] REG_HALF_WIDTH  = 3'd0;
	localparam logic [IDX_W-1:0] REG_HALF_HEIGHT = 3'd1;
	localparam logic [IDX_W-1:0] REG_COEFF_COUNT = 3'd2;
	localparam logic [IDX_W-1:0] REG_COEFF_A0    = 3'd3;
	localparam logic [IDX_W-1:0] REG_COEFF_A1    = 3'd4;
	localparam logic [IDX_W-1:0] REG_COEFF_A2    = 3'd5;
	localparam logic [IDX_W-1:0] REG_COEFF_A3    = 3'd6;

	// configuration as seen by the datapath (clamped or precomputed)
	typedef struct packed {
		logic [DIM_W-1:0]                       hw;
		logic [DIM_W-1:0]                       hh;
		logic [HSQ_W-1:0]                       hw2;
		logic [HSQ_W-1:0]                       hh2;
		logic [NUM_W-1:0]                       den;
		logic [CNT_W-1:0]                       n;
		logic [NUM_COEFF_REGS-1:0][COEF_W-1:0]  coef;
		logic signed [E_W-1:0]                  e;
	} cfg_t;

	// word passed from front to back
	typedef struct packed {
		logic [NUM_W-1:0]        num;
		logic signed [BIN_W-1:0] re;
		logic signed [BIN_W-1:0] im;
	} front_word_t;

	// result word
	typedef struct packed {
		logic signed [BIN_W-1:0] re;
		logic signed [BIN_W-1:0] im;
		logic                    sat;
	} out_word_t;

endpackage
`default_nettype wire

@@ rtl/rgain_front.sv @@
// Front end: takes bins, folds coordinates, forms the radius numerator, queues words.
`default_nettype none
module rgain_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rgain_pkg::cfg_t                   cfg,
	input  logic                              push,
	output logic                              full,
	input  logic [rgain_pkg::DIM_W-1:0]        col,
	input  logic [rgain_pkg::DIM_W-1:0]        row,
	input  logic signed [rgain_pkg::BIN_W-1:0] bin_re,
	input  logic signed [rgain_pkg::BIN_W-1:0] bin_im,
	input  logic                              take,
	output logic                              avail,
	output rgain_pkg::front_word_t            word
);
	import rgain_pkg::*;

	localparam int P_W = SQ_W + HSQ_W;

	logic                    en;
	logic                    vld_s1, vld_s2, vld_s3;
	logic [X_W-1:0]          x_s1, y_s1;
	logic [SQ_W-1:0]         x2_s2, y2_s2;
	logic [P_W-1:0]          p1_s3, p2_s3;
	logic signed [BIN_W-1:0] re_s1, im_s1, re_s2, im_s2, re_s3, im_s3;
	front_word_t             mem_q [2];
	front_word_t             wr_word;
	logic                    wp_q, rp_q;
	logic [1:0]              cnt_q;
	logic                    wr, rd;

	// fold a coordinate into the low half; coordinates past the end map to zero
	function automatic logic [X_W-1:0] fold(input logic [DIM_W-1:0] c,
		input logic [DIM_W-1:0] h);
		logic [DIM_W:0] twoh;
		logic [DIM_W:0] m;
		twoh = {h, 1'b0};
		m = twoh - (DIM_W+1)'(1) - {1'b0, c};
		if ({1'b0, c} >= twoh)
			fold = '0;
		else if (c >= h)
			fold = m[X_W-1:0];
		else
			fold = c[X_W-1:0];
	endfunction

	assign en   = (cnt_q != 2'd2);
	assign full = !en;

	// control of the three compute stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= push;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// fold, square, scale by the other axis
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1  <= fold(col, cfg.hw);
			y_s1  <= fold(row, cfg.hh);
			re_s1 <= bin_re;
			im_s1 <= bin_im;
			x2_s2 <= SQ_W'(x_s1) * SQ_W'(x_s1);
			y2_s2 <= SQ_W'(y_s1) * SQ_W'(y_s1);
			re_s2 <= re_s1;
			im_s2 <= im_s1;
			p1_s3 <= P_W'(x2_s2) * P_W'(cfg.hh2);
			p2_s3 <= P_W'(y2_s2) * P_W'(cfg.hw2);
			re_s3 <= re_s2;
			im_s3 <= im_s2;
		end
	end

	// two-entry queue toward the back end
	assign wr = en && vld_s3;
	assign rd = take && (cnt_q != 2'd0);
	always_comb begin
		wr_word.num = NUM_W'(p1_s3) + NUM_W'(p2_s3);
		wr_word.re  = re_s3;
		wr_word.im  = im_s3;
	end

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wp_q] <= wr_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr)
				wp_q <= !wp_q;
			if (rd)
				rp_q <= !rp_q;
			unique case ({wr, rd})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign avail = (cnt_q != 2'd0);
	assign word  = mem_q[rp_q];

endmodule
`default_nettype wire

@@ rtl/rgain_radius.sv @@
// Radius pipeline: bit-per-stage division for R^2, then digit-per-stage square root.
`default_nettype none
module rgain_radius (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  rgain_pkg::cfg_t                    cfg,
	input  logic                               in_vld,
	input  rgain_pkg::front_word_t             in_word,
	output logic                               out_vld,
	output logic [rgain_pkg::ROOT_W-1:0]        out_r,
	output logic signed [rgain_pkg::BIN_W-1:0] out_re,
	output logic signed [rgain_pkg::BIN_W-1:0] out_im
);
	import rgain_pkg::*;

	localparam int SR_W = ROOT_W + 2;

	logic                    dv_vld_s [0:Q_W];
	logic [NUM_W-1:0]        dv_rem_s [0:Q_W];
	logic [Q_W-1:0]          dv_q_s   [0:Q_W];
	logic signed [BIN_W-1:0] dv_re_s  [0:Q_W];
	logic signed [BIN_W-1:0] dv_im_s  [0:Q_W];

	logic                    sq_vld_s  [0:ROOT_W];
	logic [SR_W-1:0]         sq_rem_s  [0:ROOT_W];
	logic [ROOT_W-1:0]       sq_root_s [0:ROOT_W];
	logic [Q_W-1:0]          sq_bits_s [0:ROOT_W];
	logic signed [BIN_W-1:0] sq_re_s   [0:ROOT_W];
	logic signed [BIN_W-1:0] sq_im_s   [0:ROOT_W];

	// division entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dv_vld_s[0] <= 1'b0;
		else if (en)
			dv_vld_s[0] <= in_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_rem_s[0] <= in_word.num;
			dv_q_s[0]   <= '0;
			dv_re_s[0]  <= in_word.re;
			dv_im_s[0]  <= in_word.im;
		end
	end

	// one quotient bit per stage; the remainder stays below the divisor
	for (genvar g = 0; g < Q_W; g++) begin : g_div
		logic [NUM_W-1:0] sh;
		logic             ge;
		assign sh = {dv_rem_s[g][NUM_W-2:0], 1'b0};
		assign ge = (sh >= cfg.den);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_vld_s[g+1] <= 1'b0;
			else if (en)
				dv_vld_s[g+1] <= dv_vld_s[g];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_rem_s[g+1] <= ge ? (sh - cfg.den) : sh;
				dv_q_s[g+1]   <= {dv_q_s[g][Q_W-2:0], ge};
				dv_re_s[g+1]  <= dv_re_s[g];
				dv_im_s[g+1]  <= dv_im_s[g];
			end
		end
	end

	// square root entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sq_vld_s[0] <= 1'b0;
		else if (en)
			sq_vld_s[0] <= dv_vld_s[Q_W];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_rem_s[0]  <= '0;
			sq_root_s[0] <= '0;
			sq_bits_s[0] <= dv_q_s[Q_W];
			sq_re_s[0]   <= dv_re_s[Q_W];
			sq_im_s[0]   <= dv_im_s[Q_W];
		end
	end

	// one root bit per stage, two radicand bits shifted in each time
	for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
		logic [SR_W+1:0] rem2;
		logic [SR_W+1:0] trial;
		logic            ge;
		logic [SR_W+1:0] diff;
		assign rem2  = {sq_rem_s[j], sq_bits_s[j][Q_W-1:Q_W-2]};
		assign trial = {2'b00, sq_root_s[j], 2'b01};
		assign ge    = (rem2 >= trial);
		assign diff  = ge ? (rem2 - trial) : rem2;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sq_vld_s[j+1] <= 1'b0;
			else if (en)
				sq_vld_s[j+1] <= sq_vld_s[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_rem_s[j+1]  <= diff[SR_W-1:0];
				sq_root_s[j+1] <= {sq_root_s[j][ROOT_W-2:0], ge};
				sq_bits_s[j+1] <= {sq_bits_s[j][Q_W-3:0], 2'b00};
				sq_re_s[j+1]   <= sq_re_s[j];
				sq_im_s[j+1]   <= sq_im_s[j];
			end
		end
	end

	assign out_vld = sq_vld_s[ROOT_W];
	assign out_r   = sq_root_s[ROOT_W];
	assign out_re  = sq_re_s[ROOT_W];
	assign out_im  = sq_im_s[ROOT_W];

endmodule
`default_nettype wire

@@ rtl/rgain_gain.sv @@
// Gain pipeline: powers of R, polynomial, tail term division, bin scaling, result queue.
`default_nettype none
module rgain_gain (
	input  logic                               clk,
	input  logic                               arst_n,
	input  rgain_pkg::cfg_t                    cfg,
	output logic                               en,
	input  logic                               in_vld,
	input  logic [rgain_pkg::ROOT_W-1:0]        in_r,
	input  logic signed [rgain_pkg::BIN_W-1:0] in_re,
	input  logic signed [rgain_pkg::BIN_W-1:0] in_im,
	input  logic                               pop,
	output logic                               empty,
	output rgain_pkg::out_word_t               head
);
	import rgain_pkg::*;

	localparam int PW_N      = N_LIM + 1;
	localparam int TERM_W    = COEF_W + ROOT_W + 1;
	localparam int SUM_W     = TERM_W + 2;
	localparam int PM_W      = E_W + ROOT_W + 1;
	localparam int MAG_W     = PM_W - 1;
	localparam int DIV_STEPS = 6;
	localparam int DIV_STAGES = MAG_W / DIV_STEPS;
	localparam int GAIN_W    = MAG_W + 1;
	localparam int GAIN_FRAC = 28;
	localparam int G_DROP    = 12;
	localparam int G16_W     = GAIN_W - G_DROP;
	localparam int BIN_FRAC  = 16;
	localparam int PROD_W    = BIN_W + G16_W;
	localparam int RND_W     = PROD_W - BIN_FRAC;
	localparam logic signed [GAIN_W-1:0] GAIN_ONE  = GAIN_W'(1) << GAIN_FRAC;
	localparam logic signed [GAIN_W-1:0] GAIN_HALF = GAIN_W'(1) << (G_DROP - 1);
	localparam logic signed [PROD_W-1:0] PROD_HALF = PROD_W'(1) << (BIN_FRAC - 1);

	// powers and terms
	logic                     pw_vld_s  [0:PW_N];
	logic [ROOT_W-1:0]        pw_r_s    [0:PW_N];
	logic [ROOT_W-1:0]        pw_rk_s   [0:PW_N];
	logic [ROOT_W-1:0]        pw_rsel_s [0:PW_N];
	logic signed [TERM_W-1:0] pw_term_s [0:PW_N];
	logic signed [SUM_W-1:0]  pw_sum_s  [0:PW_N];
	logic signed [BIN_W-1:0]  pw_re_s   [0:PW_N];
	logic signed [BIN_W-1:0]  pw_im_s   [0:PW_N];

	// tail product and small divider
	logic                     pm_vld_s1;
	logic signed [PM_W-1:0]   pm_s1;
	logic signed [SUM_W-1:0]  sum_s1;
	logic signed [BIN_W-1:0]  re_s1, im_s1;
	logic signed [PM_W-1:0]   pm_abs;

	logic                     qd_vld_s [0:DIV_STAGES];
	logic                     qd_neg_s [0:DIV_STAGES];
	logic [MAG_W-1:0]         qd_mag_s [0:DIV_STAGES];
	logic [CNT_W-1:0]         qd_rem_s [0:DIV_STAGES];
	logic signed [SUM_W-1:0]  qd_sum_s [0:DIV_STAGES];
	logic signed [BIN_W-1:0]  qd_re_s  [0:DIV_STAGES];
	logic signed [BIN_W-1:0]  qd_im_s  [0:DIV_STAGES];
	logic [CNT_W-1:0]         dvsr;

	// gain and scaling
	logic                     vld_s3, vld_s4, vld_s5;
	logic signed [GAIN_W-1:0] gain_s3;
	logic signed [GAIN_W-1:0] gain_base;
	logic signed [GAIN_W-1:0] quot_s;
	logic signed [GAIN_W-1:0] gain_rnd;
	logic signed [G16_W-1:0]  g16_s4;
	logic signed [BIN_W-1:0]  re_s3, im_s3, re_s4, im_s4;
	logic signed [PROD_W-1:0] pre_s5, pim_s5;

	// result queue
	out_word_t                oq_q [2];
	out_word_t                res;
	logic                     oq_wp_q, oq_rp_q;
	logic [1:0]               oq_cnt_q;
	logic                     wr, rd;

	// saturate one rounded part
	function automatic logic [BIN_W:0] sat_part(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] rs;
		logic [RND_W-BIN_W:0]     hi;
		rs = p + PROD_HALF;
		hi = rs[PROD_W-1:BIN_FRAC+BIN_W-1];
		if ((&hi) || !(|hi))
			sat_part = {1'b0, rs[BIN_FRAC+BIN_W-1:BIN_FRAC]};
		else if (rs[PROD_W-1])
			sat_part = {1'b1, 1'b1, {(BIN_W-1){1'b0}}};
		else
			sat_part = {1'b1, 1'b0, {(BIN_W-1){1'b1}}};
	endfunction

	assign en   = (oq_cnt_q != 2'd2);
	assign dvsr = cfg.n + CNT_W'(2);

	// power stage entry: r^1 as the running power
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pw_vld_s[0] <= 1'b0;
		else if (en)
			pw_vld_s[0] <= in_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pw_r_s[0]    <= in_r;
			pw_rk_s[0]   <= in_r;
			pw_rsel_s[0] <= '0;
			pw_term_s[0] <= '0;
			pw_sum_s[0]  <= '0;
			pw_re_s[0]   <= in_re;
			pw_im_s[0]   <= in_im;
		end
	end

	// stage k raises the power once, forms term k-1, adds the previous term
	for (genvar k = 1; k <= PW_N; k++) begin : g_pow
		logic [2*ROOT_W-1:0]      pr;
		logic signed [TERM_W-1:0] term;
		assign pr = (2*ROOT_W)'(pw_rk_s[k-1]) * (2*ROOT_W)'(pw_r_s[k-1]);
		if (k <= N_LIM) begin : g_term
			assign term = $signed(cfg.coef[k-1]) * $signed({1'b0, pw_rk_s[k-1]});
		end else begin : g_noterm
			assign term = '0;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				pw_vld_s[k] <= 1'b0;
			else if (en)
				pw_vld_s[k] <= pw_vld_s[k-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pw_r_s[k]    <= pw_r_s[k-1];
				pw_rk_s[k]   <= pr[2*ROOT_W-1:ROOT_W];
				pw_rsel_s[k] <= ((32'(cfg.n) + 32'd1) == k) ? pr[2*ROOT_W-1:ROOT_W]
					: pw_rsel_s[k-1];
				pw_term_s[k] <= term;
				pw_sum_s[k]  <= pw_sum_s[k-1] + SUM_W'(pw_term_s[k-1]);
				pw_re_s[k]   <= pw_re_s[k-1];
				pw_im_s[k]   <= pw_im_s[k-1];
			end
		end
	end

	// E times R^(n+2)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pm_vld_s1 <= 1'b0;
		else if (en)
			pm_vld_s1 <= pw_vld_s[PW_N];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pm_s1  <= $signed(cfg.e) * $signed({1'b0, pw_rsel_s[PW_N]});
			sum_s1 <= pw_sum_s[PW_N];
			re_s1  <= pw_re_s[PW_N];
			im_s1  <= pw_im_s[PW_N];
		end
	end

	// sign and magnitude for the divide by n+2
	assign pm_abs = pm_s1[PM_W-1] ? -pm_s1 : pm_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			qd_vld_s[0] <= 1'b0;
		else if (en)
			qd_vld_s[0] <= pm_vld_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qd_neg_s[0] <= pm_s1[PM_W-1];
			qd_mag_s[0] <= pm_abs[MAG_W-1:0];
			qd_rem_s[0] <= '0;
			qd_sum_s[0] <= sum_s1;
			qd_re_s[0]  <= re_s1;
			qd_im_s[0]  <= im_s1;
		end
	end

	// restoring divide by a 3-bit constant, six quotient bits per stage
	for (genvar d = 0; d < DIV_STAGES; d++) begin : g_qdiv
		logic [MAG_W-1:0] mag;
		logic [CNT_W-1:0] rem;
		always_comb begin
			logic [CNT_W:0] t;
			mag = qd_mag_s[d];
			rem = qd_rem_s[d];
			for (int s = 0; s < DIV_STEPS; s++) begin
				t = {rem, mag[MAG_W-1]};
				if (t >= {1'b0, dvsr}) begin
					t   = t - {1'b0, dvsr};
					mag = {mag[MAG_W-2:0], 1'b1};
				end else begin
					mag = {mag[MAG_W-2:0], 1'b0};
				end
				rem = t[CNT_W-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				qd_vld_s[d+1] <= 1'b0;
			else if (en)
				qd_vld_s[d+1] <= qd_vld_s[d];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				qd_neg_s[d+1] <= qd_neg_s[d];
				qd_mag_s[d+1] <= mag;
				qd_rem_s[d+1] <= rem;
				qd_sum_s[d+1] <= qd_sum_s[d];
				qd_re_s[d+1]  <= qd_re_s[d];
				qd_im_s[d+1]  <= qd_im_s[d];
			end
		end
	end

	// gain in Q28, then rounded to Q16
	assign gain_base = GAIN_W'(qd_sum_s[DIV_STAGES]) + GAIN_ONE;
	assign quot_s    = $signed({1'b0, qd_mag_s[DIV_STAGES]});
	assign gain_rnd  = gain_s3 + GAIN_HALF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s3 <= qd_vld_s[DIV_STAGES];
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			gain_s3 <= qd_neg_s[DIV_STAGES] ? (gain_base + quot_s) : (gain_base - quot_s);
			re_s3   <= qd_re_s[DIV_STAGES];
			im_s3   <= qd_im_s[DIV_STAGES];
			g16_s4  <= gain_rnd[GAIN_W-1:G_DROP];
			re_s4   <= re_s3;
			im_s4   <= im_s3;
			pre_s5  <= PROD_W'(re_s4) * PROD_W'(g16_s4);
			pim_s5  <= PROD_W'(im_s4) * PROD_W'(g16_s4);
		end
	end

	// round, saturate, flag
	always_comb begin
		logic [BIN_W:0] a;
		logic [BIN_W:0] b;
		a = sat_part(pre_s5);
		b = sat_part(pim_s5);
		res.re  = a[BIN_W-1:0];
		res.im  = b[BIN_W-1:0];
		res.sat = a[BIN_W] | b[BIN_W];
	end

	// two-entry result queue
	assign wr = en && vld_s5;
	assign rd = pop && (oq_cnt_q != 2'd0);

	always_ff @(posedge clk) begin
		if (wr)
			oq_q[oq_wp_q] <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wp_q  <= 1'b0;
			oq_rp_q  <= 1'b0;
			oq_cnt_q <= 2'd0;
		end else begin
			if (wr)
				oq_wp_q <= !oq_wp_q;
			if (rd)
				oq_rp_q <= !oq_rp_q;
			unique case ({wr, rd})
				2'b10:   oq_cnt_q <= oq_cnt_q + 2'd1;
				2'b01:   oq_cnt_q <= oq_cnt_q - 2'd1;
				default: oq_cnt_q <= oq_cnt_q;
			endcase
		end
	end

	assign empty = (oq_cnt_q == 2'd0);
	assign head  = oq_q[oq_rp_q];

endmodule
`default_nettype wire

@@ rtl/radial_polynomial_spectrum_gain.sv @@
// Top level of the radial polynomial spectrum gain: registers, front, radius and gain.
//
//  channel  | handshake                  | words
//  ---------+----------------------------+-----------------------------------
//  input    | push / full                | col, row, bin_re, bin_im
//  result   | pop / empty                | out_re, out_im, saturated
//  config   | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// One word per cycle sustained while the result queue is not full; an accepted word passes
// the front stages, the 32-stage division, the 16-stage square root and the gain stages.
// Reset clears all control state; registers come up at their defaults.
// Front and back stall on their own: the front stops when its 2-entry queue
// fills, the back stops as a whole when the 2-entry result queue is full.
`default_nettype none
module radial_polynomial_spectrum_gain (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  logic [rgain_pkg::DIM_W-1:0]         col,
	input  logic [rgain_pkg::DIM_W-1:0]         row,
	input  logic signed [rgain_pkg::BIN_W-1:0] bin_re,
	input  logic signed [rgain_pkg::BIN_W-1:0] bin_im,
	output logic                               empty,
	input  logic                               pop,
	output logic signed [rgain_pkg::BIN_W-1:0] out_re,
	output logic signed [rgain_pkg::BIN_W-1:0] out_im,
	output logic                               saturated,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rgain_pkg::IDX_W-1:0]         cfg_index,
	input  logic [rgain_pkg::DATA_W-1:0]        cfg_data
);
	import rgain_pkg::*;

	localparam logic [DIM_W-1:0] HALF_RESET = DIM_W'(512);
	localparam logic [DIM_W-1:0] HALF_MAX   = DIM_W'(MAX_HALF_DIM);
	localparam logic [CNT_W-1:0] CNT_MAX    = CNT_W'(N_LIM);

	logic [DIM_W-1:0]                      hw_q, hh_q, hw_c, hh_c;
	logic [CNT_W-1:0]                      cnt_q, n_c;
	logic [NUM_COEFF_REGS-1:0][COEF_W-1:0] coef_raw_q, coef_q, coef_c;
	logic [HSQ_W-1:0]                      hw2_q, hh2_q;
	logic [NUM_W-1:0]                      den_q;
	logic signed [E_W-1:0]                 e_q, e_c;
	cfg_t                                  cfg;

	logic                    back_en;
	logic                    f_avail;
	front_word_t             f_word;
	logic                    r_vld;
	logic [ROOT_W-1:0]       r_val;
	logic signed [BIN_W-1:0] r_re, r_im;
	out_word_t               head;

	assign cfg_ready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_q       <= HALF_RESET;
			hh_q       <= HALF_RESET;
			cnt_q      <= '0;
			coef_raw_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_HALF_WIDTH:  hw_q <= cfg_data[DIM_W-1:0];
				REG_HALF_HEIGHT: hh_q <= cfg_data[DIM_W-1:0];
				REG_COEFF_COUNT: cnt_q <= cfg_data[CNT_W-1:0];
				REG_COEFF_A0:    coef_raw_q[0] <= cfg_data[COEF_W-1:0];
				REG_COEFF_A1:    coef_raw_q[1] <= cfg_data[COEF_W-1:0];
				REG_COEFF_A2:    coef_raw_q[2] <= cfg_data[COEF_W-1:0];
				REG_COEFF_A3:    coef_raw_q[3] <= cfg_data[COEF_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp sizes and count; unused coefficients read as zero
	always_comb begin
		hw_c = (hw_q == '0) ? DIM_W'(1) : ((hw_q > HALF_MAX) ? HALF_MAX : hw_q);
		hh_c = (hh_q == '0) ? DIM_W'(1) : ((hh_q > HALF_MAX) ? HALF_MAX : hh_q);
		n_c  = (cnt_q > CNT_MAX) ? CNT_MAX : cnt_q;
		e_c  = '0;
		for (int i = 0; i < NUM_COEFF_REGS; i++) begin
			if (32'(n_c) > i) begin
				coef_c[i] = coef_raw_q[i];
				e_c = e_c + E_W'($signed(coef_raw_q[i])) * E_W'(i + 1);
			end else begin
				coef_c[i] = '0;
			end
		end
	end

	// precomputed squares, denominator and E
	always_ff @(posedge clk) begin
		hw2_q  <= HSQ_W'(hw_c) * HSQ_W'(hw_c);
		hh2_q  <= HSQ_W'(hh_c) * HSQ_W'(hh_c);
		den_q  <= {(NUM_W-1)'(hw2_q) * (NUM_W-1)'(hh2_q), 1'b0};
		coef_q <= coef_c;
		e_q    <= e_c;
	end

	always_comb begin
		cfg.hw   = hw_c;
		cfg.hh   = hh_c;
		cfg.hw2  = hw2_q;
		cfg.hh2  = hh2_q;
		cfg.den  = den_q;
		cfg.n    = n_c;
		cfg.coef = coef_q;
		cfg.e    = e_q;
	end

	rgain_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.push   (push),
		.full   (full),
		.col    (col),
		.row    (row),
		.bin_re (bin_re),
		.bin_im (bin_im),
		.take   (back_en),
		.avail  (f_avail),
		.word   (f_word)
	);

	rgain_radius u_radius (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (back_en),
		.cfg     (cfg),
		.in_vld  (f_avail),
		.in_word (f_word),
		.out_vld (r_vld),
		.out_r   (r_val),
		.out_re  (r_re),
		.out_im  (r_im)
	);

	rgain_gain u_gain (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.en     (back_en),
		.in_vld (r_vld),
		.in_r   (r_val),
		.in_re  (r_re),
		.in_im  (r_im),
		.pop    (pop),
		.empty  (empty),
		.head   (head)
	);

	assign out_re    = head.re;
	assign out_im    = head.im;
	assign saturated = head.sat;

endmodule
`default_nettype wire
